/* rtl/core/dcq_pkg.sv */
`default_nettype none

package dcq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		OP_PUSH        = 2'd0,
		OP_PUSH_UNIQUE = 2'd1,
		OP_DRAIN       = 2'd2,
		OP_EMPTY       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] cmd;
		logic [DATA_W-1:0] arg0;
		logic [DATA_W-1:0] arg1;
		logic [DATA_W-1:0] pay;
	} entry_t;

	typedef struct packed {
		logic accepted;
		logic entry_valid;
		logic last;
	} rsp_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/dcq_ram.sv */
`default_nettype none

module dcq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/dcq_seq.sv */
`default_nettype none

module dcq_seq #(
	parameter int unsigned QUEUE_DEPTH = dcq_pkg::QUEUE_DEPTH_DEF,
	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [1:0]        opcode,
	input  wire dcq_pkg::entry_t   req_entry,
	input  wire logic              out_free,
	output logic                   rsp_load,
	output dcq_pkg::rsp_ctl_t      rsp_ctl,
	output logic                   ram_we,
	output logic [IW-1:0]          ram_waddr,
	output dcq_pkg::entry_t        ram_wdata,
	output logic                   ram_re,
	output logic [IW-1:0]          ram_raddr,
	input  wire dcq_pkg::entry_t   ram_rdata
);

	import dcq_pkg::*;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] rd_q, rd_d;
	logic [CW-1:0] rd_next;
	logic          pend_q, pend_d;
	logic          acc_q, acc_d;
	entry_t        entry_q;
	op_t           op;
	logic          full;
	logic          match;

	assign op      = op_t'(opcode);
	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign rd_next = rd_q + CW'(1);
	assign match   = (ram_rdata.cmd == entry_q.cmd) && (ram_rdata.arg0 == entry_q.arg0) &&
		(ram_rdata.arg1 == entry_q.arg1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rd_q    <= '0;
			pend_q  <= 1'b0;
			acc_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rd_q    <= rd_d;
			pend_q  <= pend_d;
			acc_q   <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			entry_q <= req_entry;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		rd_d      = rd_q;
		pend_d    = 1'b0;
		acc_d     = acc_q;
		req_ready = (state_q == S_IDLE);
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IW-1:0];
		ram_wdata = req_entry;
		ram_re    = 1'b0;
		ram_raddr = rd_q[IW-1:0];
		rsp_load  = 1'b0;
		rsp_ctl   = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (op)
						OP_PUSH, OP_PUSH_UNIQUE: begin
							if (full) begin
								acc_d   = 1'b0;
								state_d = S_RESP;
							end else if (op == OP_PUSH_UNIQUE && cnt_q != '0) begin
								rd_d    = '0;
								state_d = S_SCAN;
							end else begin
								ram_we  = 1'b1;
								cnt_d   = cnt_q + CW'(1);
								acc_d   = 1'b1;
								state_d = S_RESP;
							end
						end
						OP_DRAIN: begin
							if (cnt_q == '0) begin
								acc_d   = 1'b0;
								state_d = S_RESP;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								rd_d      = '0;
								state_d   = S_DRAIN;
							end
						end
						default: begin
							cnt_d   = '0;
							acc_d   = 1'b0;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (pend_q && match) begin
					acc_d   = 1'b0;
					state_d = S_RESP;
				end else if (rd_q == cnt_q) begin
					ram_we    = 1'b1;
					ram_wdata = entry_q;
					cnt_d     = cnt_q + CW'(1);
					acc_d     = 1'b1;
					state_d   = S_RESP;
				end else begin
					ram_re = 1'b1;
					rd_d   = rd_next;
					pend_d = 1'b1;
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					rsp_load            = 1'b1;
					rsp_ctl.entry_valid = 1'b1;
					rsp_ctl.last        = (rd_next == cnt_q);
					if (rd_next == cnt_q) begin
						cnt_d   = '0;
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = rd_next[IW-1:0];
						rd_d      = rd_next;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					rsp_load         = 1'b1;
					rsp_ctl.accepted = acc_q;
					rsp_ctl.last     = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/dedup_command_queue.sv */
`default_nettype none

// Command queue of QUEUE_DEPTH entries with duplicate suppression. Each request carries an
// opcode: push, push only if no stored entry has the same command code and both arguments,
// drain, or empty. A push, an empty and a drain of an empty queue give one response with
// last set; a drain gives one response per stored entry, oldest first, with last on the final
// one, and then clears the queue. Entries live in a single-port-write, single-port-read RAM
// with a registered read, and all searching goes through it one entry per cycle: a plain
// push or empty goes straight to its response, a conditional push first scans the stored
// entries, and a drain reads them out in order, while the request side stays not ready.
// Responses are held in an output register, so a stalled consumer stalls only the
// sequencer.
module dedup_command_queue #(
	parameter int unsigned QUEUE_DEPTH = dcq_pkg::QUEUE_DEPTH_DEF,
	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] command_code,
	input  wire logic [31:0] first_arg,
	input  wire logic [31:0] second_arg,
	input  wire logic [31:0] payload,
	input  wire logic        payload_present,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic             accepted,
	output logic             entry_valid,
	output logic [31:0]      out_command,
	output logic [31:0]      out_first_arg,
	output logic [31:0]      out_second_arg,
	output logic [31:0]      out_payload,
	output logic             last
);

	import dcq_pkg::*;

	entry_t   req_entry;
	entry_t   ram_wdata;
	entry_t   ram_rdata;
	logic     ram_we;
	logic     ram_re;
	logic [IW-1:0] ram_waddr;
	logic [IW-1:0] ram_raddr;
	logic     out_free;
	logic     rsp_load;
	rsp_ctl_t rsp_ctl;
	logic     rsp_valid_q;
	rsp_ctl_t ctl_q;
	entry_t   data_q;

	assign req_entry.cmd  = command_code;
	assign req_entry.arg0 = first_arg;
	assign req_entry.arg1 = second_arg;
	assign req_entry.pay  = payload_present ? payload : '0;

	assign out_free = !rsp_valid_q || rsp_ready;

	dcq_seq #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.opcode    (opcode),
		.req_entry (req_entry),
		.out_free  (out_free),
		.rsp_load  (rsp_load),
		.rsp_ctl   (rsp_ctl),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	dcq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			ctl_q  <= rsp_ctl;
			data_q <= rsp_ctl.entry_valid ? ram_rdata : '0;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign accepted       = ctl_q.accepted;
	assign entry_valid    = ctl_q.entry_valid;
	assign last           = ctl_q.last;
	assign out_command    = data_q.cmd;
	assign out_first_arg  = data_q.arg0;
	assign out_second_arg = data_q.arg1;
	assign out_payload    = data_q.pay;

endmodule

`default_nettype wire

/* tb/sv/dedup_command_queue_tb.sv */
module dedup_command_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dcq_pkg::*;

	typedef struct packed {
		logic        acc;
		logic        vld;
		logic [31:0] cmd;
		logic [31:0] arg0;
		logic [31:0] arg1;
		logic [31:0] pay;
		logic        lst;
	} rsp_fields_t;

	typedef struct {
		logic [31:0] cmd;
		logic [31:0] arg0;
		logic [31:0] arg1;
	} key_t;

	class cmd_queue_scoreboard;
		entry_t      stored[QUEUE_DEPTH_DEF];
		int unsigned entry_count;
		rsp_fields_t expected_rsp[$];
		int          errors;

		function new();
			entry_count = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		function void note_request(op_t op, logic [31:0] c, logic [31:0] a0,
				logic [31:0] a1, logic [31:0] p, logic pp);
			rsp_fields_t r;
			logic        dup;
			r = '0;
			dup = 1'b0;
			case (op)
				OP_PUSH, OP_PUSH_UNIQUE: begin
					if (op == OP_PUSH_UNIQUE) begin
						for (int i = 0; i < entry_count; i++) begin
							if (stored[i].cmd == c && stored[i].arg0 == a0 &&
									stored[i].arg1 == a1)
								dup = 1'b1;
						end
					end
					if (entry_count < QUEUE_DEPTH_DEF && !dup) begin
						stored[entry_count] = '{cmd: c, arg0: a0, arg1: a1,
							pay: pp ? p : 32'd0};
						entry_count++;
						r.acc = 1'b1;
					end
					r.lst = 1'b1;
					expected_rsp.push_back(r);
				end
				OP_DRAIN: begin
					if (entry_count == 0) begin
						r.lst = 1'b1;
						expected_rsp.push_back(r);
					end else begin
						for (int i = 0; i < entry_count; i++) begin
							r.vld = 1'b1;
							r.cmd = stored[i].cmd;
							r.arg0 = stored[i].arg0;
							r.arg1 = stored[i].arg1;
							r.pay = stored[i].pay;
							r.lst = (i == entry_count - 1);
							expected_rsp.push_back(r);
						end
						entry_count = 0;
					end
				end
				default: begin
					entry_count = 0;
					r.lst = 1'b1;
					expected_rsp.push_back(r);
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
			if (act_val !== exp_val) begin
				$error("%s: expected %h, actual %h", name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_response(rsp_fields_t got);
			rsp_fields_t exp_r;
			if (expected_rsp.size() == 0) begin
				$error("Response arrived with no request outstanding.");
				errors++;
			end else begin
				exp_r = expected_rsp.pop_front();
				compare_field("accepted", exp_r.acc, got.acc);
				compare_field("entry_valid", exp_r.vld, got.vld);
				compare_field("out_command", exp_r.cmd, got.cmd);
				compare_field("out_first_arg", exp_r.arg0, got.arg0);
				compare_field("out_second_arg", exp_r.arg1, got.arg1);
				compare_field("out_payload", exp_r.pay, got.pay);
				compare_field("last", exp_r.lst, got.lst);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  opcode = 2'd0;
	logic [31:0] command_code = 32'd0;
	logic [31:0] first_arg = 32'd0;
	logic [31:0] second_arg = 32'd0;
	logic [31:0] payload = 32'd0;
	logic        payload_present = 1'b0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic        accepted;
	logic        entry_valid;
	logic [31:0] out_command;
	logic [31:0] out_first_arg;
	logic [31:0] out_second_arg;
	logic [31:0] out_payload;
	logic        last;

	cmd_queue_scoreboard sb = new();
	key_t        key_pool[8];
	int          n_requests = 0;
	bit          sender_idle = 1'b0;
	bit          quiet = 1'b0;
	bit          hold_rsp = 1'b0;
	rsp_fields_t seen_rsp;

	dedup_command_queue i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.opcode          (opcode),
		.command_code    (command_code),
		.first_arg       (first_arg),
		.second_arg      (second_arg),
		.payload         (payload),
		.payload_present (payload_present),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.accepted        (accepted),
		.entry_valid     (entry_valid),
		.out_command     (out_command),
		.out_first_arg   (out_first_arg),
		.out_second_arg  (out_second_arg),
		.out_payload     (out_payload),
		.last            (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			seen_rsp = {accepted, entry_valid, out_command, out_first_arg, out_second_arg,
				out_payload, last};
			sb.check_response(seen_rsp);
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(op_t op, logic [31:0] c, logic [31:0] a0, logic [31:0] a1,
			logic [31:0] p, logic pp);
		req_valid <= 1'b1;
		opcode <= op;
		command_code <= c;
		first_arg <= a0;
		second_arg <= a1;
		payload <= p;
		payload_present <= pp;
		do @(posedge clk); while (!req_ready);
		sb.note_request(op, c, a0, a1, p, pp);
		n_requests++;
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_random(bit pushes_only);
		key_t k;
		op_t  op;
		int   r;
		r = pushes_only ? $urandom_range(0, 74) : $urandom_range(0, 99);
		if (r < 40)
			op = OP_PUSH;
		else if (r < 75)
			op = OP_PUSH_UNIQUE;
		else if (r < 90)
			op = OP_DRAIN;
		else
			op = OP_EMPTY;
		if ($urandom_range(0, 2) != 0) begin
			k = key_pool[$urandom_range(0, 7)];
		end else begin
			k.cmd = rand_word();
			k.arg0 = rand_word();
			k.arg1 = rand_word();
		end
		send_request(op, k.cmd, k.arg0, k.arg1, rand_word(), 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_all_responses();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		wait (arst_n);
		forever begin
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (!quiet && $urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		bit held;
		bit paused;
		foreach (key_pool[i]) begin
			key_pool[i].cmd = $urandom;
			key_pool[i].arg0 = $urandom;
			key_pool[i].arg1 = $urandom;
		end
		held = 1'b0;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle = 1'b1;
		send_request(OP_DRAIN, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send_request(OP_EMPTY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_request(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_request(OP_PUSH, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
		send_request(OP_PUSH_UNIQUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 1'b1);
		send_request(OP_PUSH_UNIQUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd7, 1'b1);
		send_request(OP_DRAIN, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send_request(OP_PUSH_UNIQUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd9, 1'b1);
		send_request(OP_EMPTY, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
			send_request(OP_PUSH, 32'h1000_0000 + i, ~i, i << 3, 32'hA5A5_0000 | i, i[0]);
		send_request(OP_PUSH, 32'h1234_5678, 32'd1, 32'd2, 32'd3, 1'b1);
		send_request(OP_PUSH_UNIQUE, 32'h8765_4321, 32'd4, 32'd5, 32'd6, 1'b1);
		send_request(OP_DRAIN, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);

		while (n_requests < 160) begin
			quiet = n_requests >= 135;
			sender_idle = !quiet && $urandom_range(0, 3) != 0;
			if (!held && n_requests >= 80) begin
				held = 1'b1;
				hold_rsp = 1'b1;
				sender_idle = 1'b0;
				repeat (12) send_random(1'b1);
			end else if (!paused && n_requests >= 120) begin
				paused = 1'b1;
				wait_all_responses();
			end else if ($urandom_range(0, 9) < 3) begin
				repeat ($urandom_range(12, 18)) send_random(1'b1);
				send_request(OP_DRAIN, rand_word(), rand_word(), rand_word(), rand_word(),
					1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(4, 10)) send_random(1'b0);
			end
		end

		quiet = 1'b1;
		wait_all_responses();
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
